[rtl/ps2_mouse_packet_cursor_tracker_macros.svh]
// ----------------------------------------------------------------------------
// PS/2 cursor tracker assertion macros
// Shared concurrent assertion forms, same-cycle and next-cycle.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PS2MCT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define PS2MCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ps2mct_pkg.sv]
// ----------------------------------------------------------------------------
// PS/2 cursor tracker package
// Field widths, packet codes, register indexes and the queue word type.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

   localparam int SIZE_BITS      = 13;
   localparam int CSR_INDEX_BITS = 1;
   localparam int EDGE_MARGIN    = 5;
   localparam int POS_RESET      = 500;

   localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 13'd1024;
   localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 13'd768;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_HEIGHT = 1'b1;

   localparam logic [7:0] OVF_X_BIT = 8'h40;
   localparam logic [7:0] OVF_Y_BIT = 8'h80;

   // byte slot within a three-byte packet
   localparam logic [1:0] BYTE_HEADER = 2'd0;
   localparam logic [1:0] BYTE_X      = 2'd1;
   localparam logic [1:0] BYTE_Y      = 2'd2;

   // what the back end does with one queued word
   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_APPLY = 2'd1;
   localparam logic [1:0] CMD_DROP  = 2'd2;

   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int QUEUE_CNT_BITS = 2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] dx;
      logic [7:0] dy;
   } cmd_type;

endpackage

[rtl/ps2mct_req_if.sv]
// ----------------------------------------------------------------------------
// PS/2 cursor tracker request channel
// One controller byte per word, tagged with its port of origin.
// ----------------------------------------------------------------------------
interface ps2mct_req_if;
   logic       valid;
   logic       ready;
   logic       from_aux_port;
   logic [7:0] data_byte;

   modport source (output valid, output from_aux_port, output data_byte, input ready);
   modport sink   (input valid, input from_aux_port, input data_byte, output ready);
endinterface

[rtl/ps2mct_rsp_if.sv]
// ----------------------------------------------------------------------------
// PS/2 cursor tracker response channel
// Cursor position and packet status, one word per request word.
// ----------------------------------------------------------------------------
interface ps2mct_rsp_if #(
   parameter int COORD_BITS = 12
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] cursor_x;
   logic [COORD_BITS-1:0] cursor_y;
   logic                  position_updated;
   logic                  packet_dropped;

   modport source (output valid, output cursor_x, output cursor_y,
                   output position_updated, output packet_dropped, input ready);
   modport sink   (input valid, input cursor_x, input cursor_y,
                   input position_updated, input packet_dropped, output ready);
endinterface

[rtl/ps2mct_front.sv]
// ----------------------------------------------------------------------------
// PS/2 cursor tracker front end
// Takes request bytes, assembles packets and queues one command per byte.
// ----------------------------------------------------------------------------
module ps2mct_front (
   input  logic                clock,
   input  logic                reset,
   ps2mct_req_if.sink          req_ch,
   output logic                push_valid,
   input  logic                push_ready,
   output ps2mct_pkg::cmd_type push_cmd
);

   logic [1:0] byte_pos_ff, byte_pos_in;
   logic [7:0] header_ff, header_in;
   logic [7:0] xdelta_ff, xdelta_in;
   logic       accept;

   assign req_ch.ready = push_ready;
   assign accept       = req_ch.valid && push_ready;
   assign push_valid   = req_ch.valid;

   always_comb begin
      byte_pos_in   = byte_pos_ff;
      header_in     = header_ff;
      xdelta_in     = xdelta_ff;
      push_cmd.kind = ps2mct_pkg::CMD_NONE;
      push_cmd.dx   = xdelta_ff;
      push_cmd.dy   = req_ch.data_byte;
      if (req_ch.from_aux_port) begin
         unique case (byte_pos_ff)
            ps2mct_pkg::BYTE_HEADER: begin
               header_in   = req_ch.data_byte;
               byte_pos_in = ps2mct_pkg::BYTE_X;
            end
            ps2mct_pkg::BYTE_X: begin
               xdelta_in   = req_ch.data_byte;
               byte_pos_in = ps2mct_pkg::BYTE_Y;
            end
            default: begin
               // last byte of the packet (slot 3 cannot occur, handled alike)
               byte_pos_in = ps2mct_pkg::BYTE_HEADER;
               if ((header_ff & (ps2mct_pkg::OVF_X_BIT | ps2mct_pkg::OVF_Y_BIT)) != 8'd0)
                  push_cmd.kind = ps2mct_pkg::CMD_DROP;
               else
                  push_cmd.kind = ps2mct_pkg::CMD_APPLY;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff <= ps2mct_pkg::BYTE_HEADER;
      end else if (accept) begin
         byte_pos_ff <= byte_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         header_ff <= header_in;
         xdelta_ff <= xdelta_in;
      end
   end

endmodule

[rtl/ps2mct_queue.sv]
// ----------------------------------------------------------------------------
// PS/2 cursor tracker command queue
// Two-word register queue between the front and back ends.
// ----------------------------------------------------------------------------
module ps2mct_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  ps2mct_pkg::cmd_type push_cmd,
   output logic                pop_valid,
   input  logic                pop_ready,
   output ps2mct_pkg::cmd_type pop_cmd
);

   ps2mct_pkg::cmd_type                       entry_ff [ps2mct_pkg::QUEUE_DEPTH];
   logic [ps2mct_pkg::QUEUE_PTR_BITS-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [ps2mct_pkg::QUEUE_CNT_BITS-1:0]     count_ff, count_in;
   logic                                      push, pop;

   assign push_ready = (count_ff != ps2mct_pkg::QUEUE_CNT_BITS'(ps2mct_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_cmd    = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push)
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

[rtl/ps2mct_back.sv]
// ----------------------------------------------------------------------------
// PS/2 cursor tracker back end
// Applies queued packets to the cursor, clamps it, drives the response word.
// ----------------------------------------------------------------------------
module ps2mct_back #(
   parameter int COORD_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [ps2mct_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ps2mct_pkg::SIZE_BITS-1:0]      csr_wdata,
   input  logic                                  pop_valid,
   output logic                                  pop_ready,
   input  ps2mct_pkg::cmd_type                   pop_cmd,
   ps2mct_rsp_if.source                          rsp_ch
);

   localparam int LW = (COORD_BITS > ps2mct_pkg::SIZE_BITS) ? COORD_BITS
                                                            : ps2mct_pkg::SIZE_BITS;
   localparam int SW = COORD_BITS + 2;
   localparam logic [LW-1:0] COORD_MAX = LW'((64'd1 << COORD_BITS) - 64'd1);

   logic [COORD_BITS-1:0] bound_x_ff, bound_y_ff;
   logic [COORD_BITS-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic                  rsp_valid_ff, updated_ff, dropped_ff;
   logic                  take;
   logic signed [SW-1:0]  next_x, next_y;

   // largest coordinate for a screen size: size minus margin, floored and saturated
   function automatic logic [COORD_BITS-1:0] bound_of(
      input logic [ps2mct_pkg::SIZE_BITS-1:0] size
   );
      logic [ps2mct_pkg::SIZE_BITS-1:0] lim;
      logic [LW-1:0]                    lim_w;
      lim = (size >= ps2mct_pkg::SIZE_BITS'(ps2mct_pkg::EDGE_MARGIN))
            ? size - ps2mct_pkg::SIZE_BITS'(ps2mct_pkg::EDGE_MARGIN) : '0;
      lim_w = LW'(lim);
      if (lim_w > COORD_MAX)
         return COORD_BITS'(COORD_MAX);
      return COORD_BITS'(lim_w);
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp(
      input logic signed [SW-1:0] v,
      input logic [COORD_BITS-1:0] lim
   );
      if (v < 0)
         return '0;
      if (v >= $signed({2'b00, lim}))
         return lim;
      return COORD_BITS'(v);
   endfunction

   assign pop_ready = !rsp_valid_ff || rsp_ch.ready;
   assign take      = pop_valid && pop_ready;

   assign next_x = $signed({2'b00, pos_x_ff}) + SW'($signed(pop_cmd.dx));
   assign next_y = $signed({2'b00, pos_y_ff}) - SW'($signed(pop_cmd.dy));

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      if (pop_cmd.kind == ps2mct_pkg::CMD_APPLY) begin
         pos_x_in = clamp(next_x, bound_x_ff);
         pos_y_in = clamp(next_y, bound_y_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_x_ff <= bound_of(ps2mct_pkg::WIDTH_RESET);
         bound_y_ff <= bound_of(ps2mct_pkg::HEIGHT_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            ps2mct_pkg::CSR_SCREEN_WIDTH:  bound_x_ff <= bound_of(csr_wdata);
            ps2mct_pkg::CSR_SCREEN_HEIGHT: bound_y_ff <= bound_of(csr_wdata);
            default: ;
         endcase
      end
   end

   // position registers double as the response payload: they only move on take
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= COORD_BITS'(ps2mct_pkg::POS_RESET);
         pos_y_ff     <= COORD_BITS'(ps2mct_pkg::POS_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            pos_x_ff     <= pos_x_in;
            pos_y_ff     <= pos_y_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         updated_ff <= (pop_cmd.kind == ps2mct_pkg::CMD_APPLY);
         dropped_ff <= (pop_cmd.kind == ps2mct_pkg::CMD_DROP);
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.cursor_x         = pos_x_ff;
   assign rsp_ch.cursor_y         = pos_y_ff;
   assign rsp_ch.position_updated = updated_ff;
   assign rsp_ch.packet_dropped   = dropped_ff;

endmodule

[rtl/ps2_mouse_packet_cursor_tracker.sv]
// ----------------------------------------------------------------------------
// PS/2 mouse packet cursor tracker
// Decodes three-byte mouse packets and keeps a clamped cursor position.
// ----------------------------------------------------------------------------
//   channel  dir  handshake          payload
//   req_ch   in   valid/ready        from_aux_port, data_byte
//   rsp_ch   out  valid/ready        cursor_x, cursor_y, position_updated,
//                                    packet_dropped
//   csr      in   csr_we             csr_index, csr_wdata
//
// One byte per cycle sustained while the queue has room; a response is valid
// once its byte has been written to the queue at the accepting edge, popped
// by the back end and registered by its add and clamp. The two-word queue
// lets the front keep taking bytes while a response is stalled; req_ch.ready
// drops only once the queue is full. Synchronous reset restores 1024x768,
// cursor (500,500) and a fresh packet.
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_cursor_tracker_macros.svh"

module ps2_mouse_packet_cursor_tracker #(
   parameter int COORD_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   ps2mct_req_if.sink                            req_ch,
   ps2mct_rsp_if.source                          rsp_ch,
   input  logic                                  csr_we,
   input  logic [ps2mct_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ps2mct_pkg::SIZE_BITS-1:0]      csr_wdata
);

   logic                q_push_valid, q_push_ready;
   logic                q_pop_valid, q_pop_ready;
   ps2mct_pkg::cmd_type q_push_cmd, q_pop_cmd;

   ps2mct_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_cmd   (q_push_cmd)
   );

   ps2mct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_cmd   (q_push_cmd),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_cmd    (q_pop_cmd)
   );

   ps2mct_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pop_valid (q_pop_valid),
      .pop_ready (q_pop_ready),
      .pop_cmd   (q_pop_cmd),
      .rsp_ch    (rsp_ch)
   );

   `PS2MCT_ASSERT_NEXT(a_push_lands, clock, reset, req_ch.valid && req_ch.ready, q_pop_valid, "accepted byte did not reach the queue")
   `PS2MCT_ASSERT_NEXT(a_pop_responds, clock, reset, q_pop_valid && q_pop_ready, rsp_ch.valid, "popped command gave no response")
   `PS2MCT_ASSERT_SAME(a_flags_excl, clock, reset, rsp_ch.valid, !(rsp_ch.position_updated && rsp_ch.packet_dropped), "packet both applied and dropped")

endmodule
